[hw/rtl/rws_pkg.sv]
// rws_pkg: widths, types and helpers shared by the reset-walk step modules.
// No dependencies.
`timescale 1ns / 1ps
package rws_pkg;
    localparam int DIMS_DEF      = 3;
    localparam int MAX_STEPS_DEF = 65536;
    localparam int POS_W   = 24;
    localparam int DISP_W  = 16;
    localparam int DRAW_W  = 16;
    localparam int RATE_W  = 17;
    localparam int CNT_W   = 17;
    localparam int LEN_W   = 24;
    localparam int PART_W  = 32;
    localparam int SQ_W    = 50;
    localparam int ROOT_W  = 25;
    localparam int QUEUE_DEPTH = 2;

    // Classified step carried from the front part to the back part.
    typedef struct packed {
        logic                     first_step;
        logic                     was_reset;
        logic signed [DISP_W-1:0] disp_x;
        logic signed [DISP_W-1:0] disp_y;
        logic signed [DISP_W-1:0] disp_z;
    } t_cmd;

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        begin
            hi = (POS_W+2)'(signed'({1'b0, {(POS_W-1){1'b1}}}));
            lo = -hi - (POS_W+2)'(1);
            if (v > hi) sat24 = hi[POS_W-1:0];
            else if (v < lo) sat24 = lo[POS_W-1:0];
            else sat24 = v[POS_W-1:0];
        end
    endfunction
endpackage

[hw/rtl/rws_front.sv]
// rws_front: accepts input beats, compares the draw with the reset rate and
// queues the classified step. Depends on rws_pkg.
`timescale 1ns / 1ps
module rws_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_first_step,
    input  logic [rws_pkg::DRAW_W-1:0]     i_reset_draw,
    input  logic signed [rws_pkg::DISP_W-1:0] i_disp_x,
    input  logic signed [rws_pkg::DISP_W-1:0] i_disp_y,
    input  logic signed [rws_pkg::DISP_W-1:0] i_disp_z,
    input  logic [rws_pkg::RATE_W-1:0]     i_reset_rate,
    output logic                           o_cmd_valid,
    output rws_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_take
);
    import rws_pkg::*;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [PTR_W:0]     r_cnt;
    logic               w_push, w_pop;
    t_cmd               w_cmd;

    assign o_stall     = (r_cnt == (PTR_W+1)'(QUEUE_DEPTH));
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        w_cmd.first_step = i_first_step;
        w_cmd.was_reset  = ({1'b0, i_reset_draw} < i_reset_rate);
        w_cmd.disp_x     = i_disp_x;
        w_cmd.disp_y     = i_disp_y;
        w_cmd.disp_z     = i_disp_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= w_cmd;
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + PTR_W'(1);
            if (w_pop)  r_rd <= r_rd + PTR_W'(1);
            r_cnt <= r_cnt + (PTR_W+1)'(w_push) - (PTR_W+1)'(w_pop);
        end
    end
endmodule

[hw/rtl/rws_sqrt.sv]
// rws_sqrt: bit-serial integer square root, one result bit per cycle.
// Depends on rws_pkg.
`timescale 1ns / 1ps
module rws_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rws_pkg::SQ_W-1:0]    i_value,
    output logic                        o_done,
    output logic [rws_pkg::ROOT_W-1:0]  o_root
);
    import rws_pkg::*;
    localparam int STEPS = SQ_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [SQ_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [SQ_W-1:0]   r_src;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [SQ_W+1:0]   w_trial;
    logic [SQ_W+1:0]   w_acc;

    // Restoring method: bring down two bits, try (4*root+1).
    always_comb begin
        w_acc   = {r_rem, r_src[SQ_W-1 -: 2]};
        w_trial = {{(SQ_W+2-ROOT_W-2){1'b0}}, r_root, 2'b01};
        if (w_acc >= w_trial) begin
            n_rem  = SQ_W'(w_acc - w_trial);
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = SQ_W'(w_acc);
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    assign o_root = r_root;
    assign o_done = r_busy && (r_step == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(STEPS);
            r_src  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && r_step != '0) begin
            r_step <= r_step - STEP_W'(1);
            r_src  <= {r_src[SQ_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule

[hw/rtl/rws_back.sv]
// rws_back: takes classified steps, updates position and statistics, holds
// the result beat. Depends on rws_pkg and rws_sqrt.
`timescale 1ns / 1ps
module rws_back #(
    parameter int DIMS      = rws_pkg::DIMS_DEF,
    parameter int MAX_STEPS = rws_pkg::MAX_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  rws_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_take,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [rws_pkg::POS_W-1:0] o_step_x,
    output logic signed [rws_pkg::POS_W-1:0] o_step_y,
    output logic signed [rws_pkg::POS_W-1:0] o_step_z,
    output logic                            o_was_reset,
    output logic [rws_pkg::CNT_W-1:0]       o_reset_count,
    output logic [rws_pkg::CNT_W-1:0]       o_streak,
    output logic [rws_pkg::CNT_W-1:0]       o_longest_streak,
    output logic [rws_pkg::LEN_W-1:0]       o_step_length,
    output logic [rws_pkg::PART_W-1:0]      o_partial_length,
    output logic [rws_pkg::PART_W-1:0]      o_longest_partial_length
);
    import rws_pkg::*;
    localparam logic [CNT_W-1:0] CNT_CAP =
        (MAX_STEPS < 131071) ? CNT_W'(MAX_STEPS) : CNT_W'(131071);
    localparam logic [1:0] ST_IDLE = 2'd0, ST_SQ = 2'd1, ST_ROOT = 2'd2, ST_OUT = 2'd3;

    logic [1:0]               r_state;
    logic signed [POS_W-1:0]  r_pos [3];
    logic signed [POS_W-1:0]  r_step [3];
    logic [2*POS_W-1:0]       r_sq [3];
    logic                     r_rst;
    logic                     r_go;
    logic [CNT_W-1:0]         r_resets, r_cur, r_best;
    logic [PART_W-1:0]        r_part, r_bpart;
    logic [LEN_W-1:0]         r_step_length_hold;
    logic [CNT_W-1:0]         n_cur;
    logic [PART_W-1:0]        n_part;
    logic                     w_start, w_done;
    logic [ROOT_W-1:0]        w_root;
    logic [SQ_W-1:0]          w_sum;
    logic signed [POS_W-1:0]  w_disp [3];
    logic [LEN_W-1:0]         w_len;
    logic [PART_W:0]          w_part;
    logic [POS_W-1:0]         w_abs [3];

    assign w_disp[0] = POS_W'(i_cmd.disp_x);
    assign w_disp[1] = POS_W'(i_cmd.disp_y);
    assign w_disp[2] = POS_W'(i_cmd.disp_z);

    assign o_cmd_take = (r_state == ST_IDLE) && i_cmd_valid;
    // Start the root in the same cycle that the squares land in r_sq.
    assign w_start    = r_go;
    assign w_sum      = SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
    assign w_len      = w_root[ROOT_W-1] ? {LEN_W{1'b1}} : w_root[LEN_W-1:0];
    assign w_part     = r_rst ? (PART_W+1)'(w_len)
                              : (PART_W+1)'(r_part) + (PART_W+1)'(w_len);

    always_comb begin
        for (int i = 0; i < 3; i++)
            w_abs[i] = r_step[i][POS_W-1] ? POS_W'(-r_step[i]) : r_step[i];
    end

    always_comb begin
        if (r_rst) n_cur = CNT_W'(1);
        else n_cur = (r_cur < CNT_CAP) ? r_cur + CNT_W'(1) : CNT_CAP;
        n_part = w_part[PART_W] ? {PART_W{1'b1}} : w_part[PART_W-1:0];
    end

    rws_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (w_sum),
        .o_done  (w_done),
        .o_root  (w_root)
    );

    assign o_valid     = (r_state == ST_OUT);
    assign o_step_x    = r_step[0];
    assign o_step_y    = r_step[1];
    assign o_step_z    = r_step[2];
    assign o_was_reset = r_rst;
    assign o_reset_count    = r_resets;
    assign o_streak         = r_cur;
    assign o_longest_streak = r_best;
    assign o_partial_length = r_part;
    assign o_longest_partial_length = r_bpart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_go <= 1'b0;
            for (int i = 0; i < 3; i++) r_pos[i] <= '0;
            r_resets <= '0;
            r_cur <= '0;
            r_best <= '0;
            r_part <= '0;
            r_bpart <= '0;
        end else begin
            r_go <= (r_state == ST_SQ);
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        // Step and position; first step clears the walk first.
                        for (int i = 0; i < 3; i++) begin
                            logic signed [POS_W-1:0] p;
                            logic signed [POS_W-1:0] s;
                            p = i_cmd.first_step ? '0 : r_pos[i];
                            s = sat24(i_cmd.was_reset
                                ? (POS_W+2)'(w_disp[i]) - (POS_W+2)'(p)
                                : (POS_W+2)'(w_disp[i]));
                            if (i < DIMS) begin
                                r_step[i] <= s;
                                r_pos[i]  <= sat24((POS_W+2)'(p) + (POS_W+2)'(s));
                            end else begin
                                r_step[i] <= '0;
                                r_pos[i]  <= '0;
                            end
                        end
                        r_rst <= i_cmd.was_reset;
                        if (i_cmd.first_step) begin
                            r_resets <= '0;
                            r_cur <= '0;
                            r_best <= '0;
                            r_part <= '0;
                            r_bpart <= '0;
                        end
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    for (int i = 0; i < 3; i++) r_sq[i] <= w_abs[i] * w_abs[i];
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (w_done) begin
                        r_step_length_hold <= w_len;
                        r_part <= n_part;
                        r_cur  <= n_cur;
                        if (r_rst)
                            r_resets <= (r_resets < CNT_CAP) ? r_resets + CNT_W'(1) : CNT_CAP;
                        // Longest values take the new current ones before the beat goes out.
                        if (n_cur > r_best) r_best <= n_cur;
                        if (n_part > r_bpart) r_bpart <= n_part;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_step_length = r_step_length_hold;
endmodule

[hw/rtl/reset_walk_step_with_stats_top.sv]
// Reset-walk step block: one walk step per input beat, one result beat per step.
// Each step goes through squaring, the bit-serial square root of the
// step length (one root bit per cycle, 25 bits), the update and the output
// register. A two-entry queue holds classified steps while the back part works.
// A result waits in its output register until taken. Depends on rws_pkg,
// rws_front and rws_back.
`timescale 1ns / 1ps
module reset_walk_step_with_stats_top #(
    parameter int DIMS      = rws_pkg::DIMS_DEF,
    parameter int MAX_STEPS = rws_pkg::MAX_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rws_pkg::RATE_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_first_step,
    input  logic [rws_pkg::DRAW_W-1:0]        i_reset_draw,
    input  logic signed [rws_pkg::DISP_W-1:0] i_disp_x,
    input  logic signed [rws_pkg::DISP_W-1:0] i_disp_y,
    input  logic signed [rws_pkg::DISP_W-1:0] i_disp_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [rws_pkg::POS_W-1:0]  o_step_x,
    output logic signed [rws_pkg::POS_W-1:0]  o_step_y,
    output logic signed [rws_pkg::POS_W-1:0]  o_step_z,
    output logic                              o_was_reset,
    output logic [rws_pkg::CNT_W-1:0]         o_reset_count,
    output logic [rws_pkg::CNT_W-1:0]         o_streak,
    output logic [rws_pkg::CNT_W-1:0]         o_longest_streak,
    output logic [rws_pkg::LEN_W-1:0]         o_step_length,
    output logic [rws_pkg::PART_W-1:0]        o_partial_length,
    output logic [rws_pkg::PART_W-1:0]        o_longest_partial_length
);
    import rws_pkg::*;

    logic [RATE_W-1:0] r_reset_rate;
    logic              w_cmd_valid, w_cmd_take;
    t_cmd              w_cmd;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_reset_rate <= '0;
        else if (i_cfg_valid) r_reset_rate <= i_cfg_data;
    end

    rws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_first_step (i_first_step),
        .i_reset_draw (i_reset_draw),
        .i_disp_x     (i_disp_x),
        .i_disp_y     (i_disp_y),
        .i_disp_z     (i_disp_z),
        .i_reset_rate (r_reset_rate),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_cmd_take)
    );

    rws_back #(.DIMS(DIMS), .MAX_STEPS(MAX_STEPS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_take    (w_cmd_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_step_x      (o_step_x),
        .o_step_y      (o_step_y),
        .o_step_z      (o_step_z),
        .o_was_reset   (o_was_reset),
        .o_reset_count (o_reset_count),
        .o_streak      (o_streak),
        .o_longest_streak (o_longest_streak),
        .o_step_length (o_step_length),
        .o_partial_length (o_partial_length),
        .o_longest_partial_length (o_longest_partial_length)
    );
endmodule

[hw/rtl/rws_checker.sv]
// rws_checker: port-level checks on the reset-walk step block, bound to the
// top level. Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
module rws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_was_reset,
    input logic [16:0] o_streak,
    input logic [16:0] o_longest_streak,
    input logic [31:0] o_partial_length,
    input logic [31:0] o_longest_partial_length
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_streak))
        else $error("result beat dropped while stalled");
    a_reset_streak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_reset |-> o_streak == 17'd1)
        else $error("resetting step must start a streak of one");
    a_streak_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_streak != 17'd0)
        else $error("streak of zero on a result");
    a_longest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_longest_streak >= o_streak &&
        o_longest_partial_length >= o_partial_length)
        else $error("longest value below current value");
endmodule

bind reset_walk_step_with_stats_top rws_checker u_rws_checker (
    .i_clk (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_was_reset (o_was_reset),
    .o_streak (o_streak),
    .o_longest_streak (o_longest_streak),
    .o_partial_length (o_partial_length),
    .o_longest_partial_length (o_longest_partial_length)
);

[sim/testbench.sv]
// Testbench for reset_walk_step_with_stats_top: random walk steps with resets, checked
// against a behavioral walk predictor. Depends on rws_pkg and the top-level RTL.
`timescale 1ns / 1ps
module testbench;
    import rws_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] sz;
        logic                    rst;
        logic [CNT_W-1:0]        rcount;
        logic [CNT_W-1:0]        strk;
        logic [CNT_W-1:0]        best_strk;
        logic [LEN_W-1:0]        len;
        logic [PART_W-1:0]       part;
        logic [PART_W-1:0]       best_part;
    } t_walk_result;

    localparam longint CNT_CAP = 65536;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic [RATE_W-1:0] i_cfg_data = 0;
    logic i_valid = 0;
    logic i_first_step = 0;
    logic [DRAW_W-1:0] i_reset_draw = 0;
    logic signed [DISP_W-1:0] i_disp_x = 0, i_disp_y = 0, i_disp_z = 0;
    logic i_stall = 0;
    logic o_cfg_ready, o_stall, o_valid, o_was_reset;
    logic signed [POS_W-1:0] o_step_x, o_step_y, o_step_z;
    logic [CNT_W-1:0] o_reset_count, o_streak, o_longest_streak;
    logic [LEN_W-1:0] o_step_length;
    logic [PART_W-1:0] o_partial_length, o_longest_partial_length;

    reset_walk_step_with_stats_top dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    longint rate_q;
    longint walk_pos[3];
    longint resets_q, streak_q, best_streak_q, partial_q, best_partial_q;
    t_walk_result expected_steps[$];
    int mismatches = 0;
    int results_seen = 0;
    int steps_sent = 0;
    bit calm = 0;       // no idling on either side
    int hold_cycles = 0; // receiver hold-off

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint n);
        longint r = 0;
        longint b = 64'sd1 << 60;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void clear_walk_stats();
        for (int i = 0; i < 3; i++) walk_pos[i] = 0;
        resets_q = 0; streak_q = 0; best_streak_q = 0;
        partial_q = 0; best_partial_q = 0;
    endfunction

    function automatic t_walk_result predict_step(logic first, logic [15:0] draw,
                                                  logic signed [15:0] dx,
                                                  logic signed [15:0] dy,
                                                  logic signed [15:0] dz);
        t_walk_result r;
        longint d[3];
        longint s[3];
        longint sumsq = 0;
        longint len, p;
        bit jump;
        d[0] = dx; d[1] = dy; d[2] = dz;
        if (first) clear_walk_stats();
        jump = longint'(draw) < rate_q;
        for (int i = 0; i < 3; i++) begin
            s[i] = clamp24(jump ? d[i] - walk_pos[i] : d[i]);
            walk_pos[i] = clamp24(walk_pos[i] + s[i]);
            sumsq += s[i] * s[i];
        end
        len = floor_sqrt(sumsq);
        if (len > 64'hFFFFFF) len = 64'hFFFFFF;
        if (jump) begin
            resets_q = (resets_q < CNT_CAP) ? resets_q + 1 : CNT_CAP;
            streak_q = 1;
            p = len;
        end else begin
            streak_q = (streak_q < CNT_CAP) ? streak_q + 1 : CNT_CAP;
            p = partial_q + len;
        end
        if (p > 64'hFFFFFFFF) p = 64'hFFFFFFFF;
        partial_q = p;
        if (streak_q > best_streak_q) best_streak_q = streak_q;
        if (partial_q > best_partial_q) best_partial_q = partial_q;
        r.sx = POS_W'(s[0]); r.sy = POS_W'(s[1]); r.sz = POS_W'(s[2]);
        r.rst = jump;
        r.rcount = CNT_W'(resets_q); r.strk = CNT_W'(streak_q);
        r.best_strk = CNT_W'(best_streak_q);
        r.len = LEN_W'(len); r.part = PART_W'(partial_q);
        r.best_part = PART_W'(best_partial_q);
        return r;
    endfunction

    // Send one step; idles at random unless calm.
    task automatic send_step(logic first, logic [15:0] draw, logic signed [15:0] dx,
                             logic signed [15:0] dy, logic signed [15:0] dz);
        while (!calm && $urandom_range(99) < 30) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_first_step <= first; i_reset_draw <= draw;
        i_disp_x <= dx; i_disp_y <= dy; i_disp_z <= dz;
        expected_steps.push_back(predict_step(first, draw, dx, dy, dz));
        steps_sent++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (expected_steps.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [RATE_W-1:0] v);
        wait_drained();
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        rate_q = v;
    endtask

    function automatic logic signed [15:0] gauss_like();
        int sel = $urandom_range(9);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
        return $signed(16'($urandom_range(16383))) - 16'sd8192;
    endfunction

    task automatic random_step(int first_pct);
        send_step($urandom_range(99) < first_pct, 16'($urandom), gauss_like(),
                  gauss_like(), gauss_like());
    endtask

    // Checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_walk_result got;
            t_walk_result want;
            got = '{o_step_x, o_step_y, o_step_z, o_was_reset, o_reset_count, o_streak,
                    o_longest_streak, o_step_length, o_partial_length,
                    o_longest_partial_length};
            results_seen++;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %0d", results_seen);
            end else begin
                want = expected_steps.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: exp %p\n          got %p", results_seen,
                                 want, got);
                end
            end
        end
    end

    // Receiver stall, with a counted hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1;
        end else begin
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
        end
    end

    task automatic test_extremes();
        write_rate(17'd0);
        send_step(1'b1, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_step(1'b0, 16'h0000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_step(1'b0, 16'h1234, 16'sh0000, 16'sh0000, 16'sh0000);
        for (int i = 0; i < 6; i++)
            send_step(1'b0, 16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        write_rate(17'd65536);
        send_step(1'b0, 16'hFFFF, 16'sh0001, -16'sh0001, 16'sh5555);
        send_step(1'b0, 16'h0000, -16'sh8000, 16'sh7FFF, 16'sh0000);
        send_step(1'b1, 16'hAAAA, 16'sh2AAA, 16'sh5555, -16'sh2AAB);
        write_rate(17'h08000);
        send_step(1'b0, 16'h7FFF, 16'sh0100, 16'sh0000, 16'sh0000);
        send_step(1'b0, 16'h8000, 16'sh0100, 16'sh0000, 16'sh0000);
        send_step(1'b0, 16'h8001, 16'sh0000, 16'sh0100, 16'sh0000);
        send_step(1'b1, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0100);
    endtask

    task automatic test_random_rates();
        logic [RATE_W-1:0] rates[4] = '{17'd0, 17'd3000, 17'd20000, 17'd65536};
        for (int ph = 0; ph < 4; ph++) begin
            write_rate(ph == 2 ? 17'($urandom_range(65536)) : rates[ph]);
            for (int k = 0; k < 90; k++) random_step(3);
        end
    endtask

    task automatic test_back_pressure();
        write_rate(17'd6000);
        hold_cycles = 300;
        for (int k = 0; k < 20; k++) random_step(0);
        wait_drained();
        calm = 1;
        for (int k = 0; k < 60; k++) random_step(2);
        calm = 0;
        for (int k = 0; k < 40; k++) random_step(5);
    endtask

    initial begin
        rate_q = 0;
        clear_walk_stats();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_extremes();
        test_random_rates();
        test_back_pressure();
        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("%0d steps sent over rates 0..65536, %0d results checked",
                 steps_sent, results_seen);
        if (mismatches == 0 && expected_steps.size() == 0)
            $display("reset_walk_step_with_stats_top: match");
        else
            $display("reset_walk_step_with_stats_top: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("reset_walk_step_with_stats_top: mismatch");
        $finish;
    end
endmodule
